// ===== src/mtb_pkg.sv =====
// Shared constants, codes and types of the multiplexed timer bank.
package mtb_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int TICK_W = 32;
	localparam int DX_W = 16;
	localparam logic [DX_W-1:0] PERIOD_MIN = 16'd2;
	localparam logic [DX_W-1:0] PERIOD_MAX = 16'd65533;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_RAISE = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACK  = 2'd0,
		KIND_FIRE = 2'd1,
		KIND_NEXT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK,
		ST_RD,
		ST_EVAL,
		ST_MOD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [TICK_W-1:0] reload;
		logic              irq;
	} cfg_word_t;

	typedef struct packed {
		logic            start;
		logic [DX_W-1:0] dividend;
		logic [TICK_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic            done;
		logic [DX_W-1:0] remainder;
	} mod_rsp_t;

endpackage

// ===== src/mtb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mtb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/mtb_mod.sv =====
// Restoring remainder unit: one dividend bit per cycle, for the periodic overrun.
module mtb_mod import mtb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	localparam int CNT_W = $clog2(DX_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DX_W-1:0]     dvd_q;
	logic [DX_W-1:0]     rem_q;
	logic [TICK_W-1:0]   dsr_q;
	logic [DX_W:0]       trial;
	logic [TICK_W-1:0]   trial_ext;
	logic [TICK_W-1:0]   diff;
	logic [DX_W-1:0]     rem_d;

	// The partial remainder never exceeds the dividend prefix, so it fits DX_W bits.
	always_comb begin
		trial = {rem_q, dvd_q[DX_W-1]};
		trial_ext = TICK_W'(trial);
		diff = trial_ext - dsr_q;
		if (trial_ext >= dsr_q) begin
			rem_d = diff[DX_W-1:0];
		end else begin
			rem_d = trial[DX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DX_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign rsp.done = done_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== src/multiplexed_timer_bank.sv =====
// Multiplexed timer bank: sixteen logical timers sharing one compare channel.
// Start, stop and raise pass through the acknowledge state, which pushes the acknowledge
// item once the output register is free. A tick walks the slots: an idle slot is skipped,
// an armed slot is read and then evaluated, each periodic slot that fires waits for the
// bit-serial remainder unit, and the walk ends with the delay item; output stalls hold it.
// Reset clears the armed bits and the control state; the slot RAMs are not cleared.
module multiplexed_timer_bank import mtb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [1:0]          operation,
	input  logic [3:0]          slot,
	input  logic [TICK_W-1:0]   interval,
	input  logic                repeat_req,
	input  logic                call_in_irq,
	input  logic [DX_W-1:0]     elapsed,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [1:0]          kind,
	output logic [3:0]          fired_slot,
	output logic                in_irq,
	output logic                was_active,
	output logic [DX_W-1:0]     next_delay,
	output logic                last
);

	// Sequencer state and the captured request item.
	state_t              state_q, state_d;
	op_t                 op_q;
	logic [3:0]          slot_q;
	logic [TICK_W-1:0]   interval_q;
	logic                rep_q;
	logic                cirq_q;
	logic [DX_W-1:0]     dx_q;

	// Tick walk: current slot and running minimum of the remaining counts.
	logic [IDX_W-1:0]    idx_q;
	logic [DX_W-1:0]     ccr_q;
	logic [NUM_TIMERS-1:0] armed_q;

	// Output register; it frees up in the same cycle the consumer takes it.
	logic                rsp_valid_q;
	kind_t               kind_q;
	logic [3:0]          fired_slot_q;
	logic                in_irq_q;
	logic                was_active_q;
	logic [DX_W-1:0]     next_delay_q;
	logic                last_q;
	logic                out_free;

	// Result being pushed into the output register this cycle.
	logic                push;
	kind_t               p_kind;
	logic [3:0]          p_slot;
	logic                p_irq;
	logic                p_act;
	logic [DX_W-1:0]     p_delay;
	logic                p_last;

	// RAM ports.
	logic                rd_en;
	logic                rem_we;
	logic [IDX_W-1:0]    rem_waddr;
	logic [TICK_W-1:0]   rem_wdata;
	logic [TICK_W-1:0]   rem_rd;
	logic                cfg_we;
	cfg_word_t           cfg_wdata;
	cfg_word_t           cfg_rd;

	// Armed bit updates, walk control and the minimum tracker.
	logic                arm_set;
	logic                arm_clr;
	logic [IDX_W-1:0]    arm_idx;
	logic [IDX_W-1:0]    slot_addr;
	logic                slot_ok;
	logic                idx_inc;
	logic                cand_ld;
	logic [TICK_W-1:0]   cand;
	logic                fire;
	logic                last_slot;
	logic [TICK_W-1:0]   dx_ext;

	mod_req_t            mod_req;
	mod_rsp_t            mod_rsp;

	// Remaining ticks per slot; written by start, raise and by a tick for each armed slot that stays armed.
	mtb_ram #(
		.WIDTH (TICK_W),
		.DEPTH (NUM_TIMERS)
	) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rem_rd)
	);

	// Reload value and interrupt-context flag; written only by start.
	mtb_ram #(
		.WIDTH ($bits(cfg_word_t)),
		.DEPTH (NUM_TIMERS)
	) u_cfg_ram (
		.clk   (clk),
		.we    (cfg_we),
		.waddr (slot_addr),
		.wdata (cfg_wdata),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (cfg_rd)
	);

	mtb_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	assign slot_addr = IDX_W'(slot_q);
	assign slot_ok = (32'(slot_q) < NUM_TIMERS);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign dx_ext = TICK_W'(dx_q);
	assign fire = (rem_rd <= dx_ext);
	assign last_slot = (idx_q == IDX_W'(NUM_TIMERS - 1));

	always_comb begin
		state_d = state_q;
		req_ready = (state_q == ST_IDLE);
		push = 1'b0;
		p_kind = KIND_ACK;
		p_slot = slot_q;
		p_irq = 1'b0;
		p_act = 1'b0;
		p_delay = '0;
		p_last = 1'b0;
		rd_en = 1'b0;
		rem_we = 1'b0;
		rem_waddr = idx_q;
		rem_wdata = rem_rd - dx_ext;
		cfg_we = 1'b0;
		cfg_wdata.reload = rep_q ? interval_q : '0;
		cfg_wdata.irq = cirq_q;
		arm_set = 1'b0;
		arm_clr = 1'b0;
		arm_idx = idx_q;
		idx_inc = 1'b0;
		cand_ld = 1'b0;
		cand = rem_rd - dx_ext;
		mod_req.start = 1'b0;
		// The overrun past the deadline is below 2^16 because remaining <= elapsed.
		mod_req.dividend = dx_q - rem_rd[DX_W-1:0];
		mod_req.divisor = cfg_rd.reload;

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (op_t'(operation) == OP_TICK) ? ST_RD : ST_ACK;
				end
			end

			ST_ACK: begin
				arm_idx = slot_addr;
				rem_waddr = slot_addr;
				if (out_free) begin
					push = 1'b1;
					p_last = 1'b1;
					state_d = ST_IDLE;
					unique case (op_q)
						OP_START: begin
							if (slot_ok) begin
								rem_we = 1'b1;
								rem_wdata = interval_q;
								cfg_we = 1'b1;
								arm_set = 1'b1;
								p_delay = PERIOD_MIN;
							end
						end
						OP_STOP: begin
							if (slot_ok && armed_q[slot_addr]) begin
								arm_clr = 1'b1;
								p_act = 1'b1;
							end
						end
						OP_RAISE: begin
							if (slot_ok && armed_q[slot_addr]) begin
								rem_we = 1'b1;
								rem_wdata = '0;
								p_delay = PERIOD_MIN;
							end
						end
						default: begin
						end
					endcase
				end
			end

			ST_RD: begin
				if (armed_q[idx_q]) begin
					rd_en = 1'b1;
					state_d = ST_EVAL;
				end else if (last_slot) begin
					state_d = ST_DONE;
				end else begin
					idx_inc = 1'b1;
				end
			end

			ST_EVAL: begin
				if (!fire) begin
					rem_we = 1'b1;
					cand_ld = 1'b1;
					if (last_slot) begin
						state_d = ST_DONE;
					end else begin
						idx_inc = 1'b1;
						state_d = ST_RD;
					end
				end else if (out_free) begin
					push = 1'b1;
					p_kind = KIND_FIRE;
					p_slot = 4'(idx_q);
					p_irq = cfg_rd.irq;
					if (cfg_rd.reload == '0) begin
						// One-shot: disarmed and left out of the minimum.
						arm_clr = 1'b1;
						if (last_slot) begin
							state_d = ST_DONE;
						end else begin
							idx_inc = 1'b1;
							state_d = ST_RD;
						end
					end else begin
						mod_req.start = 1'b1;
						state_d = ST_MOD;
					end
				end
			end

			ST_MOD: begin
				cand = cfg_rd.reload - TICK_W'(mod_rsp.remainder);
				rem_wdata = cand;
				if (mod_rsp.done) begin
					rem_we = 1'b1;
					cand_ld = 1'b1;
					if (last_slot) begin
						state_d = ST_DONE;
					end else begin
						idx_inc = 1'b1;
						state_d = ST_RD;
					end
				end
			end

			ST_DONE: begin
				if (out_free) begin
					push = 1'b1;
					p_kind = KIND_NEXT;
					p_slot = '0;
					p_last = 1'b1;
					p_delay = (ccr_q < PERIOD_MIN) ? PERIOD_MIN : ccr_q;
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request capture; every accepted request also restarts the walk and the minimum.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q <= op_t'(operation);
			slot_q <= slot;
			interval_q <= interval;
			rep_q <= repeat_req;
			cirq_q <= call_in_irq;
			dx_q <= elapsed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ccr_q <= PERIOD_MAX;
		end else if (req_valid && req_ready) begin
			idx_q <= '0;
			ccr_q <= PERIOD_MAX;
		end else begin
			if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cand_ld && (cand < TICK_W'(ccr_q))) begin
				ccr_q <= cand[DX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (arm_set) begin
			armed_q[arm_idx] <= 1'b1;
		end else if (arm_clr) begin
			armed_q[arm_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q <= p_kind;
			fired_slot_q <= p_slot;
			in_irq_q <= p_irq;
			was_active_q <= p_act;
			next_delay_q <= p_delay;
			last_q <= p_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign kind = kind_q;
	assign fired_slot = fired_slot_q;
	assign in_irq = in_irq_q;
	assign was_active = was_active_q;
	assign next_delay = next_delay_q;
	assign last = last_q;

endmodule

// ===== src/mtb_checker.sv =====
// Port-level checks of the timer bank's result stream, bound to the top level.
module mtb_checker import mtb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [1:0]        kind,
	input logic [3:0]        fired_slot,
	input logic              in_irq,
	input logic              was_active,
	input logic [DX_W-1:0]   next_delay,
	input logic              last
);

	// A stalled result item holds still.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(next_delay)
			&& $stable(fired_slot) && $stable(last))
		else $error("result item changed while stalled");

	// The compare delay item closes a tick and lies within the compare limits.
	a_next_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_NEXT |-> last && next_delay >= PERIOD_MIN
			&& next_delay <= PERIOD_MAX && fired_slot == 4'd0)
		else $error("bad compare delay item");

	// A fire item is never the final item of a tick.
	a_fire_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_FIRE |-> !last && next_delay == '0 && !was_active)
		else $error("bad fire item");

	// An acknowledge carries either the forced compare delay or none.
	a_ack_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_ACK |-> last && !in_irq
			&& (next_delay == '0 || next_delay == PERIOD_MIN)
			&& !(was_active && next_delay != '0))
		else $error("bad acknowledge item");

	// No request is taken while a tick's fire items are still being produced.
	a_no_req_mid_tick: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == KIND_FIRE |-> !(req_valid && req_ready))
		else $error("request accepted during a tick");

endmodule

bind multiplexed_timer_bank mtb_checker u_mtb_checker (.*);
